>>> design/stli_pkg.sv
// Package for the sorted table linear interpolator.
// Holds table sizes, operation and status codes, sequencer states and divider structs.
// No dependencies.
package stli_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_FEW     = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_INS_CMP = 10'b00_0000_0010,
    S_INS_FIN = 10'b00_0000_0100,
    S_Q_FIRST = 10'b00_0000_1000,
    S_Q_LAST  = 10'b00_0001_0000,
    S_Q_SCAN  = 10'b00_0010_0000,
    S_Q_MUL   = 10'b00_0100_0000,
    S_Q_DIV   = 10'b00_1000_0000,
    S_Q_ADD   = 10'b01_0000_0000,
    S_OUT     = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [2*DATA_W-1:0]   dividend;
    logic [DATA_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/stli_if.sv
// Channel interfaces for the sorted table linear interpolator.
// Depends on stli_pkg for field widths.
interface stli_in_if import stli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;
  modport source (output valid, operation, x_value, y_value, input ready);
  modport sink   (input valid, operation, x_value, y_value, output ready);
endinterface

interface stli_out_if import stli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_result;
  logic [1:0]               status;
  logic [CNT_W-1:0]         point_count;
  logic signed [DATA_W-1:0] y_min;
  logic signed [DATA_W-1:0] y_max;
  modport source (output valid, y_result, status, point_count, y_min, y_max, input ready);
  modport sink   (input valid, y_result, status, point_count, y_min, y_max, output ready);
endinterface

interface stli_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/stli_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on stli_pkg for the request and response structs.
module stli_div import stli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEPS = 2 * DATA_W;
  localparam int CW    = $clog2(STEPS + 1);

  logic                busy_r;
  logic [CW-1:0]       cnt_r;
  logic [DATA_W:0]     rem_r;
  logic [STEPS-1:0]    dvd_r;
  logic [DATA_W-1:0]   dvs_r;
  logic                done_r;
  logic [DATA_W:0]     sh;
  logic                qbit;

  assign sh   = {rem_r[DATA_W-1:0], dvd_r[STEPS-1]};
  assign qbit = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= qbit ? (sh - {1'b0, dvs_r}) : sh;
        dvd_r <= {dvd_r[STEPS-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r[DATA_W-1:0];

endmodule

>>> design/sorted_table_linear_interpolator.sv
// Top level of the sorted table linear interpolator: point memory and sequencer.
// Depends on stli_pkg, the channel interfaces and stli_div.
//
//  channel | dir | payload                                         | handshake
//  in_if   | in  | operation, x_value, y_value                     | valid/ready
//  out_if  | out | y_result, status, point_count, y_min, y_max     | valid/ready
//  cfg_if  | in  | data = zero_outside                             | valid/ready
//
// Insert: reads the last entry, shifts larger entries up, writes the new point;
// one memory port pair. Query: reads both end entries, scans for the segment,
// multiplies, divides and adds; it stops early outside the range, at an end x
// or with under two points. Clear, full insert and insert into an empty table go
// straight to the output. One item at a time; the result register holds until
// taken while the next item is accepted. Synchronous reset, no clearing pass.
module sorted_table_linear_interpolator import stli_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  stli_in_if.sink   in_if,
  stli_out_if.source out_if,
  stli_cfg_if.sink  cfg_if
);

  state_t state_r, state_nxt;

  logic [2*DATA_W-1:0] mem [MAX_POINTS];
  logic [2*DATA_W-1:0] mem_q;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic                wr_en;
  logic [2*DATA_W-1:0] wr_data;

  logic signed [DATA_W-1:0] mx, my;

  logic                     zo_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [DATA_W-1:0] min_r, max_r;
  logic signed [DATA_W-1:0] x_r, y_r;
  logic [ADDR_W-1:0]        pos_r, j_r, last_r;
  logic signed [DATA_W-1:0] fx_r, fy_r, px_r, py_r, ys_r;
  logic                     neg_r;
  logic [DATA_W-1:0]        mag_r, num_r, den_r;
  logic [2*DATA_W-1:0]      prod_r;
  logic                     div_go_r;
  logic signed [DATA_W-1:0] res_y_r;
  status_t                  res_st_r;
  logic                     out_valid_r;

  logic signed [DATA_W:0]   dy;
  logic [DATA_W:0]          dy_abs;
  logic                     accept;

  div_req_t dreq;
  div_rsp_t drsp;

  assign mx = mem_q[2*DATA_W-1:DATA_W];
  assign my = mem_q[DATA_W-1:0];

  stli_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign dreq.start    = div_go_r;
  assign dreq.dividend = prod_r;
  assign dreq.divisor  = den_r;

  assign accept       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;

  assign dy     = {my[DATA_W-1], my} - {py_r[DATA_W-1], py_r};
  assign dy_abs = dy[DATA_W] ? -dy : dy;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = {x_r, y_r};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_if.operation))
            OP_INSERT: begin
              wr_addr = '0;
              wr_data = {in_if.x_value, in_if.y_value};
              rd_addr = ADDR_W'(count_r - 1'b1);
              if (count_r >= CNT_W'(MAX_POINTS)) begin
                state_nxt = S_OUT;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_INS_CMP;
              end
            end
            OP_QUERY: begin
              state_nxt = (count_r < CNT_W'(2)) ? S_OUT : S_Q_FIRST;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (mx > x_r) begin
          wr_data = mem_q;
          rd_addr = pos_r - ADDR_W'(2);
          state_nxt = (pos_r == ADDR_W'(1)) ? S_INS_FIN : S_INS_CMP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_INS_FIN: begin
        wr_en     = 1'b1;
        state_nxt = S_OUT;
      end
      S_Q_FIRST: begin
        rd_addr   = last_r;
        state_nxt = (x_r < mx) ? S_OUT : S_Q_LAST;
      end
      S_Q_LAST: begin
        rd_addr = ADDR_W'(1);
        if (x_r >= mx || x_r == fx_r) state_nxt = S_OUT;
        else state_nxt = S_Q_SCAN;
      end
      S_Q_SCAN: begin
        rd_addr = j_r + 1'b1;
        if (mx >= x_r) state_nxt = S_Q_MUL;
      end
      S_Q_MUL: state_nxt = S_Q_DIV;
      S_Q_DIV: begin
        if (drsp.done) state_nxt = S_Q_ADD;
      end
      S_Q_ADD: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_if.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      zo_r        <= 1'b0;
      count_r     <= '0;
      min_r       <= {1'b0, {(DATA_W-1){1'b1}}};
      max_r       <= {1'b1, {(DATA_W-1){1'b0}}};
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (state_r == S_Q_MUL);
      if (cfg_if.valid && cfg_if.ready) zo_r <= cfg_if.data;
      if (out_valid_r && out_if.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r      <= in_if.x_value;
            y_r      <= in_if.y_value;
            pos_r    <= ADDR_W'(count_r);
            last_r   <= ADDR_W'(count_r - 1'b1);
            res_y_r  <= '0;
            res_st_r <= ST_OK;
            case (op_t'(in_if.operation))
              OP_INSERT: begin
                if (count_r >= CNT_W'(MAX_POINTS)) begin
                  res_st_r <= ST_FULL;
                end else begin
                  count_r <= count_r + 1'b1;
                  if (in_if.y_value < min_r) min_r <= in_if.y_value;
                  if (in_if.y_value > max_r) max_r <= in_if.y_value;
                end
              end
              OP_QUERY: begin
                if (count_r < CNT_W'(2)) res_st_r <= ST_FEW;
              end
              OP_CLEAR: begin
                count_r <= '0;
                min_r   <= {1'b0, {(DATA_W-1){1'b1}}};
                max_r   <= {1'b1, {(DATA_W-1){1'b0}}};
              end
              default: ;
            endcase
          end
        end
        S_INS_CMP: begin
          if (mx > x_r) pos_r <= pos_r - 1'b1;
        end
        S_Q_FIRST: begin
          fx_r <= mx;
          fy_r <= my;
          px_r <= mx;
          py_r <= my;
          j_r  <= ADDR_W'(1);
          if (x_r < mx) begin
            res_st_r <= ST_OUTSIDE;
            res_y_r  <= zo_r ? '0 : my;
          end
        end
        S_Q_LAST: begin
          if (x_r > mx) begin
            res_st_r <= ST_OUTSIDE;
            res_y_r  <= zo_r ? '0 : my;
          end else if (x_r == mx) begin
            res_y_r <= my;
          end else if (x_r == fx_r) begin
            res_y_r <= fy_r;
          end
        end
        S_Q_SCAN: begin
          if (mx >= x_r) begin
            ys_r  <= py_r;
            neg_r <= dy[DATA_W];
            mag_r <= dy_abs[DATA_W-1:0];
            num_r <= DATA_W'(x_r - px_r);
            den_r <= DATA_W'(mx - px_r);
          end else begin
            px_r <= mx;
            py_r <= my;
            j_r  <= j_r + 1'b1;
          end
        end
        S_Q_MUL: prod_r <= mag_r * num_r;
        S_Q_ADD: res_y_r <= neg_r ? (ys_r - $signed(prod_r[DATA_W-1:0]))
                                  : (ys_r + $signed(prod_r[DATA_W-1:0]));
        S_OUT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r        <= 1'b1;
            out_if.y_result    <= res_y_r;
            out_if.status      <= res_st_r;
            out_if.point_count <= count_r;
            out_if.y_min       <= min_r;
            out_if.y_max       <= max_r;
          end
        end
        default: ;
      endcase
      if (state_r == S_Q_DIV && drsp.done) prod_r <= {{DATA_W{1'b0}}, drsp.quotient};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS)) else $error("point count above table size");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE || state_r == S_INS_CMP || state_r == S_INS_FIN))
    else $error("memory write outside insert");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_SCAN) |-> (j_r <= last_r)) else $error("scan past last entry");
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r)) else $error("y min above y max");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_Q_DIV)) else $error("divider done outside divide");
`endif

endmodule
